// File: rtl/mrrp_pkg.sv
package mrrp_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_MS     = 1'b1;

  localparam logic [7:0]  RESET_DEVICE_ADDRESS = 8'd1;
  localparam logic [15:0] RESET_TIMEOUT_MS     = 16'd1000;

  localparam logic [7:0]  REPLY_FUNC  = 8'h03;
  localparam logic [7:0]  REPLY_COUNT = 8'h02;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic [15:0] speed_tenths;
  } result_t;

  // Modbus CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mrrp_parser.sv
module mrrp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [1:0]           mode,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           device_address,
  input  logic [15:0]          timeout_ms,
  output mrrp_pkg::result_t    res
);
  import mrrp_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR, PH_FUNC, PH_COUNT, PH_VAL_HI, PH_VAL_LO, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t      phase, phase_next;
  logic        armed, armed_next;
  logic [15:0] elapsed, elapsed_next;
  logic [15:0] crc, crc_next;
  logic [15:0] reading, reading_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [15:0] crc_upd;
  logic        clear;

  assign crc_upd = crc_add((phase == PH_ADDR) ? CRC_SEED : crc, rx_byte);

  always_comb begin
    phase_next   = phase;
    armed_next   = armed;
    elapsed_next = elapsed;
    crc_next     = crc;
    reading_next = reading;
    crc_lo_next  = crc_lo;
    clear        = 1'b0;
    res          = '0;
    if (go) begin
      if (mode == MODE_START) begin
        armed_next   = 1'b1;
        elapsed_next = '0;
        clear        = 1'b1;
      end else if (armed && mode == MODE_TICK) begin
        if (elapsed >= timeout_ms) begin
          armed_next = 1'b0;
          clear      = 1'b1;
          res.valid  = 1'b1;
          res.status = STATUS_TIMEOUT;
        end else begin
          elapsed_next = elapsed + 16'd1;
        end
      end else if (armed && mode == MODE_BYTE) begin
        case (phase)
          PH_ADDR: begin
            if (rx_byte == device_address) begin
              crc_next   = crc_upd;
              phase_next = PH_FUNC;
            end
          end
          PH_FUNC: begin
            if (rx_byte == REPLY_FUNC) begin
              crc_next   = crc_upd;
              phase_next = PH_COUNT;
            end else begin
              clear = 1'b1;
            end
          end
          PH_COUNT: begin
            if (rx_byte == REPLY_COUNT) begin
              crc_next   = crc_upd;
              phase_next = PH_VAL_HI;
            end else begin
              clear = 1'b1;
            end
          end
          PH_VAL_HI: begin
            reading_next = {rx_byte, 8'h00};
            crc_next     = crc_upd;
            phase_next   = PH_VAL_LO;
          end
          PH_VAL_LO: begin
            reading_next = {reading[15:8], rx_byte};
            crc_next     = crc_upd;
            phase_next   = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            crc_lo_next = rx_byte;
            phase_next  = PH_CRC_HI;
          end
          default: begin
            // A bad checksum drops the frame without a result.
            if (crc_lo == crc[7:0] && rx_byte == crc[15:8]) begin
              armed_next       = 1'b0;
              res.valid        = 1'b1;
              res.status       = STATUS_OK;
              res.speed_tenths = reading;
            end
            clear = 1'b1;
          end
        endcase
      end
    end
    if (clear) begin
      phase_next   = PH_ADDR;
      crc_next     = CRC_SEED;
      reading_next = '0;
      crc_lo_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_ADDR;
      armed   <= 1'b0;
      elapsed <= '0;
      crc     <= CRC_SEED;
      reading <= '0;
      crc_lo  <= '0;
    end else begin
      phase   <= phase_next;
      armed   <= armed_next;
      elapsed <= elapsed_next;
      crc     <= crc_next;
      reading <= reading_next;
      crc_lo  <= crc_lo_next;
    end
  end

endmodule

// File: rtl/mrrp_out_reg.sv
module mrrp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  mrrp_pkg::result_t res,
  output logic              out_valid,
  output logic              status,
  output logic [15:0]       speed_tenths
);
  import mrrp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      status       <= res.status;
      speed_tenths <= res.speed_tenths;
    end
  end

endmodule

// File: rtl/modbus_rtu_reply_parser_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  mode[1:0], received_byte[7:0]
// out      out_valid/ out_stall status, speed_tenths[15:0]
// cfg      cfg_we               cfg_index[0], cfg_data[15:0]
//
// One beat per cycle sustained while the output is not stalled; a beat that causes
// a result is held in the input register, then the parser updates the output register.
// The byte-wide CRC update sits between those two registers and sets the path.
// Reset (rst, synchronous) disarms the session and loads the register defaults.
// A stalled output holds its beat; the input register then fills and in_stall rises.
module modbus_rtu_reply_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  received_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [15:0] speed_tenths,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mrrp_pkg::*;

  logic [7:0]  device_address;
  logic [15:0] timeout_ms;
  logic        in_q_valid;
  logic [1:0]  in_q_mode;
  logic [7:0]  in_q_byte;
  logic        advance;
  logic        accept;
  result_t     res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= RESET_DEVICE_ADDRESS;
      timeout_ms     <= RESET_TIMEOUT_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        CFG_TIMEOUT_MS:     timeout_ms     <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= accept || (in_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_mode <= mode;
      in_q_byte <= received_byte;
    end
  end

  mrrp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .go             (in_q_valid && advance),
    .mode           (in_q_mode),
    .rx_byte        (in_q_byte),
    .device_address (device_address),
    .timeout_ms     (timeout_ms),
    .res            (res)
  );

  mrrp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .res          (res),
    .out_valid    (out_valid),
    .status       (status),
    .speed_tenths (speed_tenths)
  );

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_TIMEOUT |-> speed_tenths == 16'd0)
    else $error("timeout beat carries a nonzero reading");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q_mode) && $stable(in_q_byte))
    else $error("pending input item lost while output stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_q_valid)
    else $error("input stalled without a blocked output");

endmodule
